### rtl/vlc_pkg.sv
`timescale 1ns / 1ps

package vlc_pkg;

  localparam int WORD_BITS = 32;
  localparam int ESC_E     = 5;

  localparam logic [4:0] TBL_ESC_LO   = 5'd0;
  localparam logic [4:0] TBL_ESC_HI   = 5'd5;
  localparam logic [4:0] TBL_ESC_SIX  = 5'd6;
  localparam logic [4:0] TBL_ESC_SEVN = 5'd7;
  localparam logic [4:0] TBL_SHORT    = 5'd8;
  localparam logic [4:0] TBL_EXPG     = 5'd10;
  localparam logic [4:0] TBL_UNARY_LO = 5'd11;
  localparam logic [4:0] TBL_UNARY_HI = 5'd18;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_RANGE = 2'd1;
  localparam logic [1:0] ERR_TABLE = 2'd2;
  localparam logic [1:0] ERR_LONG  = 2'd3;

  typedef struct packed {
    logic signed [5:0] opcode;
    logic [31:0]       value;
  } vlc_in_t;

  typedef struct packed {
    logic [5:0]  code_length;
    logic        word_valid;
    logic [31:0] word_out;
    logic [1:0]  error;
  } vlc_out_t;

  typedef struct packed {
    logic [31:0] code;
    logic [5:0]  len;
    logic [1:0]  err;
  } vlc_code_t;

endpackage

### rtl/vlc_coder.sv
`timescale 1ns / 1ps

module vlc_coder import vlc_pkg::*; (
  input  vlc_in_t   item_i,
  output vlc_code_t code_o
);

  logic        neg;
  logic [4:0]  tbl;
  logic [31:0] val;
  logic [5:0]  raw_len;

  logic        esc;
  logic [2:0]  esc_n;
  logic [32:0] esc_cn;
  logic [7:0]  esc_lim;
  logic        esc_small;
  logic [7:0]  esc_quot;

  logic [32:0] log_x;
  logic        log_hi;
  logic [3:0]  log_k;
  logic [6:0]  long_len;
  logic [4:0]  m_full;
  logic [3:0]  m;

  assign neg     = item_i.opcode[5];
  assign tbl     = item_i.opcode[4:0];
  assign val     = item_i.value;
  assign raw_len = 6'(~item_i.opcode) + 6'd1;

  always_comb begin
    esc    = 1'b0;
    esc_n  = tbl[2:0];
    esc_cn = {1'b0, val};
    if (!neg) begin
      unique case (tbl) inside
        [TBL_ESC_LO:TBL_ESC_HI]: esc = 1'b1;
        TBL_ESC_SIX: begin
          if (val != 32'd0) begin
            esc    = 1'b1;
            esc_n  = 3'd2;
            esc_cn = {1'b0, val} + 33'd1;
          end
        end
        TBL_ESC_SEVN: begin
          if (val > 32'd3) begin
            esc    = 1'b1;
            esc_n  = 3'd3;
            esc_cn = {1'b0, val} + 33'd4;
          end
        end
        default: ;
      endcase
    end
  end

  assign esc_lim   = 8'(ESC_E) << esc_n;
  assign esc_small = esc_cn < {25'd0, esc_lim};
  assign esc_quot  = esc_cn[7:0] >> esc_n;

  // Shared leading-one search for the escape tail and the exp-Golomb table
  assign log_x  = (tbl == TBL_EXPG) ? ({1'b0, val} + 33'd1)
                                    : (esc_cn - (33'(ESC_E - 1) << esc_n));
  assign log_hi = |log_x[32:16];

  always_comb begin
    log_k = 4'd0;
    for (int i = 1; i < 16; i++) begin
      if (log_x[i]) log_k = 4'(i);
    end
  end

  assign long_len = 7'(ESC_E + 1) - {4'd0, esc_n} + {2'd0, log_k, 1'b0};
  assign m_full   = tbl - TBL_EXPG;
  assign m        = m_full[3:0];

  always_comb begin
    code_o = '0;
    if (neg) begin
      code_o.len  = raw_len;
      code_o.code = val;
    end else if (esc) begin
      if (esc_small) begin
        code_o.code = (32'd1 << esc_n) | (esc_cn[31:0] & ((32'd1 << esc_n) - 32'd1));
        code_o.len  = 6'd1 + {3'd0, esc_n} + {3'd0, esc_quot[2:0]};
      end else if (log_hi || long_len > 7'(WORD_BITS)) begin
        code_o.err = ERR_LONG;
      end else begin
        code_o.len  = long_len[5:0];
        code_o.code = log_x[31:0];
      end
    end else begin
      unique case (tbl) inside
        TBL_ESC_SIX: begin
          code_o.len  = 6'd2;
          code_o.code = 32'd2;
        end
        TBL_ESC_SEVN: begin
          if (val == 32'd0) begin
            code_o.len  = 6'd2;
            code_o.code = 32'd2;
          end else if (val == 32'd1) begin
            code_o.len  = 6'd3;
            code_o.code = 32'd6;
          end else begin
            code_o.len  = 6'd4;
            code_o.code = 32'd14 + {31'd0, val[0]};
          end
        end
        TBL_SHORT: begin
          if (val > 32'd9) begin
            code_o.err = ERR_RANGE;
          end else if (val < 32'd6) begin
            code_o.len  = 6'd2 + {4'd0, val[2:1]};
            code_o.code = 32'd2 + {31'd0, val[0]};
          end else begin
            code_o.len  = 6'd5;
            code_o.code = val - 32'd6;
          end
        end
        TBL_EXPG: begin
          if (log_hi) begin
            code_o.err = ERR_LONG;
          end else begin
            code_o.len  = {1'b0, log_k, 1'b0} + 6'd1;
            code_o.code = log_x[31:0];
          end
        end
        [TBL_UNARY_LO:TBL_UNARY_HI]: begin
          if (val > {28'd0, m}) begin
            code_o.err = ERR_RANGE;
          end else if (val == {28'd0, m}) begin
            code_o.len = {2'd0, m};
          end else begin
            code_o.len  = {2'd0, val[3:0]} + 6'd1;
            code_o.code = 32'd1;
          end
        end
        default: code_o.err = ERR_TABLE;
      endcase
    end
  end

endmodule

### rtl/vlc_encoder_bit_packer.sv
`timescale 1ns / 1ps

// Variable-length code encoder with an MSB-first 32-bit bit packer.
// Input channel (in_valid_i / in_ready_o / in_data_i): one item per symbol,
// opcode 0..8 or 10..18 picks a code table, a negative opcode writes that many raw
// bits from the low end of value.
// Output channel (out_valid_o / out_ready_i / out_data_o): exactly one result
// item per input item: code length, error code and any 32-bit word flushed.
// A word is flushed only when an item needs more bits than the buffer has free.
// An item is held in the input register, then coded and packed into the
// result register when the output is free to advance.
// Throughput: one item per cycle while the receiver takes results, limited by
// the buffer update between the input register and the result register.
// Reset empties the buffer (32 bits free) and both registers.
// When the receiver stalls, the result holds; one more item is taken into
// the input register, after which in_ready_o drops until the result is taken.
// An item in error writes no bits and leaves the buffer untouched.

module vlc_encoder_bit_packer import vlc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  vlc_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output vlc_out_t out_data_o
);

  logic        in_valid_q, in_valid_d;
  vlc_in_t     in_q;
  logic        out_valid_q, out_valid_d;
  vlc_out_t    out_q;
  logic [31:0] buf_q, buf_d;
  logic [5:0]  free_q, free_d;

  logic        adv, accept, fire;
  vlc_code_t   cw;
  logic [31:0] mask, cm;
  logic [5:0]  sh;
  logic [63:0] wide;
  logic        flush;
  vlc_out_t    res;

  vlc_coder u_coder (
    .item_i (in_q),
    .code_o (cw)
  );

  assign adv         = !out_valid_q || out_ready_i;
  assign in_ready_o  = !in_valid_q || adv;
  assign accept      = in_valid_i && in_ready_o;
  assign fire        = in_valid_q && adv;
  assign in_valid_d  = accept || (in_valid_q && !fire);
  assign out_valid_d = fire || (out_valid_q && !out_ready_i);

  assign mask  = 32'((33'd1 << cw.len) - 33'd1);
  assign cm    = cw.code & mask;
  assign sh    = 6'({1'b0, free_q} + 7'(WORD_BITS) - {1'b0, cw.len});
  assign wide  = {buf_q, 32'd0} | ({32'd0, cm} << sh);
  assign flush = cw.len > free_q;

  always_comb begin
    res    = '0;
    buf_d  = buf_q;
    free_d = free_q;
    res.error = cw.err;
    if (cw.err == ERR_NONE) begin
      res.code_length = cw.len;
      if (flush) begin
        res.word_valid = 1'b1;
        res.word_out   = wide[63:32];
        buf_d          = wide[31:0];
        free_d         = sh;
      end else begin
        buf_d  = wide[63:32];
        free_d = free_q - cw.len;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      buf_q       <= '0;
      free_q      <= 6'(WORD_BITS);
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        buf_q  <= buf_d;
        free_q <= free_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_data_i;
    if (fire) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= 6'(WORD_BITS))
    else $error("free bit count out of range");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(buf_q) && $stable(free_q))
    else $error("buffer changed without an item");

  a_free_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && cw.err == ERR_NONE && !flush |=> free_q == $past(free_q) - $past(cw.len))
    else $error("free count not reduced by code length");

  a_err_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.error != ERR_NONE |->
      out_q.code_length == 6'd0 && !out_q.word_valid)
    else $error("item in error wrote bits");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.code_length <= 6'(WORD_BITS))
    else $error("code length over word size");

endmodule
